@@ rtl/scfc_pkg.sv @@
// Package for the sensor frame CRC checker: constants, status codes and the CRC byte update.
package scfc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned POS_W  = 3;

  localparam logic [WORD_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY  = 16'hA001;
  localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h03;
  localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h04;
  localparam logic [WORD_W-1:0] SIGN_BIT  = 16'h8000;
  localparam logic [WORD_W-1:0] MAG_MASK  = 16'h7FFF;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_HDR0     = 3'd0;
  localparam logic [POS_W-1:0] POS_HDR1     = 3'd1;
  localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd2;
  localparam logic [POS_W-1:0] POS_HUM_LO   = 3'd3;
  localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd4;
  localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_HDR_ERR = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd2;
  localparam logic [1:0] STATUS_UNUSED  = 2'd3;

  // One byte of CRC-16/MODBUS, reflected, LSB first
  function automatic logic [WORD_W-1:0] crc_byte_update(input logic [WORD_W-1:0] crc_in,
                                                        input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/sensor_frame_crc_checker.sv @@
// Sensor response frame checker: header check, CRC-16/MODBUS and field decode.
// The result is registered at the edge that takes the eighth byte of a frame.
// Throughput: one byte per cycle; input stalls only while a held result is stalled at the output
// and the byte count points at a frame's final byte, even when frame_start restarts the frame.
// Reset (rst, synchronous): byte count to 0, CRC to 0xFFFF, header flag set, output empty.
module sensor_frame_crc_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [scfc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [scfc_pkg::WORD_W-1:0]  humidity_tenths,
  output logic signed [scfc_pkg::WORD_W-1:0] temperature_tenths
);
  import scfc_pkg::*;

  logic [POS_W-1:0]  byte_position;
  logic [WORD_W-1:0] crc_accumulator;
  logic              header_ok;
  logic [WORD_W-1:0] humidity_word;
  logic [WORD_W-1:0] temperature_word;
  logic [BYTE_W-1:0] crc_low_byte;

  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] crc_base;
  logic [WORD_W-1:0] crc_next;
  logic              header_base;
  logic              header_ok_next;
  logic              accept;
  logic              result_fire;
  logic [WORD_W-1:0] received_crc;
  logic [WORD_W-1:0] temp_mag;
  logic [WORD_W-1:0] temp_twos;
  logic [1:0]        status_next;
  logic [WORD_W-1:0] hum_next;
  logic [WORD_W-1:0] temp_next;

  // Only the final byte of a frame needs room in the output register
  assign in_stall = out_valid && out_stall && (byte_position == POS_CRC_HI);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos            = frame_start ? POS_HDR0 : byte_position;
    crc_base       = (pos == POS_HDR0) ? CRC_INIT : crc_accumulator;
    header_base    = (pos == POS_HDR0) ? 1'b1 : header_ok;
    crc_next       = crc_base;
    header_ok_next = header_base;
    if (pos < POS_CRC_LO) begin
      crc_next = crc_byte_update(crc_base, rx_byte);
    end
    case (pos)
      POS_HDR0: begin
        if (rx_byte != HDR_BYTE0) header_ok_next = 1'b0;
      end
      POS_HDR1: begin
        if (rx_byte != HDR_BYTE1) header_ok_next = 1'b0;
      end
      default: ;
    endcase
    result_fire = accept && (pos == POS_CRC_HI);

    received_crc = {rx_byte, crc_low_byte};
    temp_mag     = temperature_word & MAG_MASK;
    // sign-magnitude to two's complement; negative zero folds to zero
    temp_twos    = ((temperature_word & SIGN_BIT) != '0) ? (~temp_mag + 1'b1) : temp_mag;
    if (!header_ok) begin
      status_next = STATUS_HDR_ERR;
      hum_next    = '0;
      temp_next   = '0;
    end else begin
      status_next = (received_crc != crc_accumulator) ? STATUS_CRC_ERR : STATUS_OK;
      hum_next    = humidity_word;
      temp_next   = temp_twos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_accumulator <= CRC_INIT;
      header_ok       <= 1'b1;
      humidity_word   <= '0;
      temperature_word <= '0;
      crc_low_byte    <= '0;
    end else if (accept) begin
      byte_position   <= pos + 1'b1;
      crc_accumulator <= crc_next;
      header_ok       <= header_ok_next;
      case (pos)
        POS_HUM_HI:  humidity_word[15:8]    <= rx_byte;
        POS_HUM_LO:  humidity_word[7:0]     <= rx_byte;
        POS_TEMP_HI: temperature_word[15:8] <= rx_byte;
        POS_TEMP_LO: temperature_word[7:0]  <= rx_byte;
        POS_CRC_LO:  crc_low_byte           <= rx_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      status             <= status_next;
      humidity_tenths    <= hum_next;
      temperature_tenths <= signed'(temp_next);
    end
  end

  a_hdr_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_HDR_ERR) |-> (humidity_tenths == '0 &&
      temperature_tenths == '0))
    else $error("header error result carries nonzero fields");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept && !frame_start && byte_position == POS_CRC_HI))
    else $error("result without a final frame byte");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != STATUS_UNUSED)
    else $error("illegal status code");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_start) |=> byte_position == POS_HDR1)
    else $error("frame start did not restart byte count");

endmodule
